// ===== hdl/status_frame_change_detector_macros.svh =====
// Assertion macros for the status frame change detector.
// Used by status_frame_change_detector.sv; expects clk_i and rst_ni in scope.
`ifndef STATUS_FRAME_CHANGE_DETECTOR_MACROS_SVH
`define STATUS_FRAME_CHANGE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sfcd_pkg.sv =====
// Package for the status frame change detector: frame layout, codes, result type.
// No dependencies.
`default_nettype none

package sfcd_pkg;

  localparam int unsigned SELECTIONS = 48;
  localparam int unsigned TEXT_CHARS = 32;
  localparam int unsigned TIDX_W     = $clog2(TEXT_CHARS);
  localparam int unsigned TCNT_W     = TIDX_W + 1;
  localparam int unsigned CREDIT_N   = 8;

  localparam int unsigned POS_W = 7;
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_STATE  = 7'd3;
  localparam pos_t POS_FLAGS  = 7'd9;
  localparam pos_t POS_TEXT   = 7'd11;
  localparam pos_t POS_AVAIL  = POS_W'(POS_TEXT + 2 * TEXT_CHARS);
  localparam pos_t POS_BEEP   = 7'd81;
  localparam pos_t POS_BEEP_H = 7'd82;
  localparam pos_t POS_LANG   = 7'd83;
  localparam pos_t POS_IMP    = 7'd86;
  localparam pos_t POS_CREDIT = 7'd87;
  localparam pos_t POS_MAX    = 7'd127;

  localparam logic [15:0] CH_SPACE   = 16'h0020;
  localparam logic [15:0] CH_AT      = 16'h0040;
  localparam logic [7:0]  LANG_MULTI = 8'h31;
  localparam logic [7:0]  IMP_NONE   = 8'hff;
  localparam logic [22:0] BEEP_SCALE = 23'd100;

  localparam logic [7:0] VER_BEEP   = 8'd1;
  localparam logic [7:0] VER_LANG   = 8'd2;
  localparam logic [7:0] VER_CREDIT = 8'd3;

  // Change flag bit positions
  localparam int unsigned DF_STATE  = 0;
  localparam int unsigned DF_CREDIT = 1;
  localparam int unsigned DF_AVAIL  = 2;
  localparam int unsigned DF_TEXT   = 3;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic [7:0]  importance;
    logic        text_changed;
    logic        avail_changed;
    logic        credit_changed;
    logic [22:0] beep_ms;
    logic [1:0]  prep_state;
    logic        stop_allowed;
    logic        cup_absent;
    logic [7:0]  error_type;
    logic [7:0]  error_code;
    logic [7:0]  machine_state;
    logic        state_changed;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/status_frame_change_detector.sv =====
// Status frame change detector, top level: byte parser, stores and result register.
// Depends on sfcd_pkg and status_frame_change_detector_macros.svh.
//
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] data_byte, tlast last_byte
// m_axis    out  tdata[63:0] result fields, one transfer per frame
// cfg       in   cfg_wdata_i ctrl_version, written when cfg_we_i is high
//
// One byte per cycle unless stalled; each byte is parsed into the stores.
// The last byte fills the unreceived positions with zero (availability with 1)
// in that same cycle and loads the result register; the result appears
// the cycle after. Input stalls only while the result register is full and
// not being taken. Reset clears all stores, the position and the result valid.
`default_nettype none

`include "status_frame_change_detector_macros.svh"

module status_frame_change_detector
  import sfcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,   // [7:0] ctrl_version
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata   // [0] state_changed, [8:1] machine_state,
                                          // [16:9] error_code, [24:17] error_type,
                                          // [25] cup_absent, [26] stop_allowed,
                                          // [28:27] prep_state, [51:29] beep_ms,
                                          // [52] credit_changed, [53] avail_changed,
                                          // [54] text_changed, [62:55] importance
);

  logic [7:0]              ver_q;
  pos_t                    pos_q, pos_d;
  logic [7:0]              low_q, low_d;
  logic [15:0]             fns_q, fns_d;
  logic [7:0]              flags_q, flags_d;
  logic [7:0]              beep_lo_q, beep_lo_d;
  logic [7:0]              beep_hi_q, beep_hi_d;
  logic [7:0]              lang_q, lang_d;
  logic [7:0]              imp_q, imp_d;
  logic [3:0]              diff_q, diff_d;
  logic [15:0]             text_q [TEXT_CHARS];
  logic [15:0]             text_d [TEXT_CHARS];
  logic [7:0]              credit_q [CREDIT_N];
  logic [7:0]              credit_d [CREDIT_N];
  logic [SELECTIONS-1:0]   avail_q, avail_d;
  logic [7:0]              state_q [3];
  logic [7:0]              state_d [3];
  logic [7:0]              prev_imp_q, prev_imp_d;
  logic                    spaced_q, spaced_d;
  logic                    known_q;
  result_t                 out_q, res;
  logic                    out_valid_q;

  logic                    s_acc;
  logic                    last;
  logic [7:0]              din;
  logic                    in_text, hi;
  pos_t                    off;
  logic [TIDX_W-1:0]       idx;
  logic [15:0]             char_now, part_char, fns1;
  logic                    part;
  logic [TCNT_W-1:0]       fill_start;
  logic                    text_diff;
  logic [7:0]              beep_lo_n, beep_hi_n, lang_n, imp_n, flags_n, imp_fin;
  logic                    multi, at_final, spaced;
  logic                    hit;
  logic [7:0]              bval;
  logic                    av;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign last          = s_axis_tlast;
  assign din           = s_axis_tdata;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  always_comb begin
    diff_d    = diff_q;
    text_d    = text_q;
    credit_d  = credit_q;
    avail_d   = avail_q;
    state_d   = state_q;
    low_d     = low_q;
    hit       = 1'b0;
    bval      = '0;
    av        = 1'b0;

    // state bytes, with zero fill past the last byte
    for (int k = 0; k < 3; k++) begin
      hit  = (pos_q == POS_W'(POS_STATE + k)) || (last && pos_q < POS_W'(POS_STATE + k));
      bval = (pos_q == POS_W'(POS_STATE + k)) ? din : 8'h00;
      if (hit && state_q[k] != bval) begin
        diff_d[DF_STATE] = 1'b1;
        state_d[k]       = bval;
      end
    end

    // text characters
    in_text    = (pos_q >= POS_TEXT) && (pos_q < POS_AVAIL);
    off        = pos_q - POS_TEXT;
    hi         = off[0];
    idx        = off[TIDX_W:1];
    char_now   = {din, low_q};
    part       = last && in_text && !hi;
    part_char  = {8'h00, din};
    text_diff  = 1'b0;
    if (in_text && hi) begin
      text_diff   = text_q[idx] != char_now;
      text_d[idx] = char_now;
    end
    if (in_text && !hi) begin
      low_d = din;
    end
    fns1 = fns_q;
    if (in_text && hi && idx < TIDX_W'(TEXT_CHARS / 2) && fns_q == CH_SPACE &&
        char_now != CH_SPACE) begin
      fns1 = char_now;
    end

    if (pos_q < POS_TEXT) begin
      fill_start = '0;
    end else if (in_text) begin
      fill_start = {1'b0, idx} + TCNT_W'(1);
    end else begin
      fill_start = TCNT_W'(TEXT_CHARS);
    end
    if (last) begin
      for (int j = 0; j < TEXT_CHARS; j++) begin
        if (TCNT_W'(j) >= fill_start) begin
          if (text_q[j] != 16'h0000) begin
            text_diff = 1'b1;
          end
          text_d[j] = 16'h0000;
        end
      end
      if (part) begin
        if (text_q[idx] != part_char) begin
          text_diff = 1'b1;
        end
        text_d[idx] = part_char;
      end
    end
    if (text_diff) begin
      diff_d[DF_TEXT] = 1'b1;
    end
    at_final = (fns1 == CH_AT) ||
               (fns1 == CH_SPACE && part && idx < TIDX_W'(TEXT_CHARS / 2) &&
                part_char == CH_AT);

    // availability, stored as 1 = available
    for (int i = 0; i < SELECTIONS; i++) begin
      hit = (pos_q == POS_W'(POS_AVAIL + i / 8)) ||
            (last && pos_q < POS_W'(POS_AVAIL + i / 8));
      av  = (pos_q == POS_W'(POS_AVAIL + i / 8)) ? !din[i % 8] : 1'b1;
      if (hit && av != avail_q[i]) begin
        diff_d[DF_AVAIL] = 1'b1;
        avail_d[i]       = av;
      end
    end

    // credit bytes
    for (int c = 0; c < CREDIT_N; c++) begin
      hit  = (ver_q >= VER_CREDIT) &&
             ((pos_q == POS_W'(POS_CREDIT + c)) || (last && pos_q < POS_W'(POS_CREDIT + c)));
      bval = (pos_q == POS_W'(POS_CREDIT + c)) ? din : 8'h00;
      if (hit && credit_q[c] != bval) begin
        diff_d[DF_CREDIT] = 1'b1;
        credit_d[c]       = bval;
      end
    end

    flags_n   = (pos_q == POS_FLAGS)  ? din : flags_q;
    beep_lo_n = (pos_q == POS_BEEP)   ? din : beep_lo_q;
    beep_hi_n = (pos_q == POS_BEEP_H) ? din : beep_hi_q;
    lang_n    = (pos_q == POS_LANG)   ? din : lang_q;
    imp_n     = (pos_q == POS_IMP)    ? din : imp_q;

    multi   = (ver_q >= VER_LANG) && (lang_n == LANG_MULTI);
    imp_fin = (ver_q >= VER_CREDIT) ? imp_n : IMP_NONE;
    if (avail_d == '0) begin
      imp_fin = IMP_NONE;
    end
    spaced = !(multi && at_final);

    res.state_changed  = diff_d[DF_STATE];
    res.machine_state  = state_d[0];
    res.error_code     = state_d[1];
    res.error_type     = state_d[2];
    res.cup_absent     = flags_n[3];
    res.stop_allowed   = flags_n[4];
    res.prep_state     = flags_n[6:5];
    res.beep_ms        = (ver_q >= VER_BEEP) ? (23'({beep_hi_n, beep_lo_n}) * BEEP_SCALE)
                                             : 23'd0;
    res.credit_changed = diff_d[DF_CREDIT];
    res.avail_changed  = diff_d[DF_AVAIL];
    res.text_changed   = !known_q || (spaced != spaced_q) || diff_d[DF_TEXT] ||
                         (imp_fin != prev_imp_q);
    res.importance     = imp_fin;

    spaced_d   = spaced;
    prev_imp_d = imp_fin;

    // per-frame working registers: advance or clear
    if (last) begin
      pos_d     = '0;
      low_d     = '0;
      fns_d     = CH_SPACE;
      flags_d   = '0;
      beep_lo_d = '0;
      beep_hi_d = '0;
      lang_d    = '0;
      imp_d     = '0;
      diff_d    = '0;
    end else begin
      pos_d     = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;
      fns_d     = fns1;
      flags_d   = flags_n;
      beep_lo_d = beep_lo_n;
      beep_hi_d = beep_hi_n;
      lang_d    = lang_n;
      imp_d     = imp_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q       <= '0;
      pos_q       <= '0;
      low_q       <= '0;
      fns_q       <= CH_SPACE;
      flags_q     <= '0;
      beep_lo_q   <= '0;
      beep_hi_q   <= '0;
      lang_q      <= '0;
      imp_q       <= '0;
      diff_q      <= '0;
      text_q      <= '{default: '0};
      credit_q    <= '{default: '0};
      avail_q     <= '0;
      state_q     <= '{default: '0};
      prev_imp_q  <= '0;
      spaced_q    <= 1'b0;
      known_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ver_q <= cfg_wdata_i;
      end
      if (s_acc) begin
        pos_q     <= pos_d;
        low_q     <= low_d;
        fns_q     <= fns_d;
        flags_q   <= flags_d;
        beep_lo_q <= beep_lo_d;
        beep_hi_q <= beep_hi_d;
        lang_q    <= lang_d;
        imp_q     <= imp_d;
        diff_q    <= diff_d;
        text_q    <= text_d;
        credit_q  <= credit_d;
        avail_q   <= avail_d;
        state_q   <= state_d;
        if (last) begin
          prev_imp_q <= prev_imp_d;
          spaced_q   <= spaced_d;
          known_q    <= 1'b1;
        end
      end
      if (s_acc && last) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && last) begin
      out_q <= res;
    end
  end

  `SFCD_ASSERT_NXT(a_pos_adv, s_acc && !last && pos_q != POS_MAX, pos_q == $past(pos_q) + POS_W'(1), "position did not advance")
  `SFCD_ASSERT_NXT(a_frame_clr, s_acc && last, pos_q == '0 && diff_q == '0 && fns_q == CH_SPACE, "frame state not cleared")
  `SFCD_ASSERT_IMP(a_valid_src, $rose(out_valid_q), $past(s_acc && last), "result without last transfer")
  `SFCD_ASSERT_NXT(a_imp_none, s_acc && last, avail_q != '0 || out_q.importance == IMP_NONE, "importance not forced")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for status_frame_change_detector: directed frames, then random frames
// over several protocol versions and handshake idling patterns, checked against a local predictor.
// Depends on sfcd_pkg and the RTL of the block.
module tb;
  import sfcd_pkg::*;

  localparam int unsigned FRAME_LEN   = 95;
  localparam int unsigned FRAME_END   = FRAME_LEN - 1;
  localparam int unsigned DIR_N       = 25;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_BYTES = 60;
  localparam int unsigned PHASE_FRMS  = 1;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // fields from importance down to state_changed
  localparam result_t RES_NONE    = '0;
  localparam result_t RES_FIRST   = {8'hff, 1'b1, 1'b1, 1'b0, 23'd0, 2'd0, 1'b0, 1'b0,
                                     8'h00, 8'h00, 8'h00, 1'b0};
  localparam result_t RES_REPEAT  = {8'hff, 1'b0, 1'b0, 1'b0, 23'd0, 2'd0, 1'b0, 1'b0,
                                     8'h00, 8'h00, 8'h00, 1'b0};
  localparam result_t RES_FLAGS   = {8'hff, 1'b0, 1'b0, 1'b0, 23'd0, 2'd3, 1'b1, 1'b1,
                                     8'h80, 8'h00, 8'hff, 1'b1};
  localparam result_t RES_CLEARED = {8'hff, 1'b0, 1'b0, 1'b0, 23'd0, 2'd0, 1'b0, 1'b0,
                                     8'h00, 8'h00, 8'h00, 1'b1};

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } dir_row_t;

  dir_row_t dir_rows [DIR_N] = '{
    '{8'hff, 1'b1, 1'b1, RES_FIRST},
    '{8'h00, 1'b1, 1'b1, RES_REPEAT},
    '{8'h11, 1'b0, 1'b0, RES_NONE},
    '{8'h22, 1'b0, 1'b0, RES_NONE},
    '{8'h33, 1'b0, 1'b0, RES_NONE},
    '{8'hff, 1'b0, 1'b0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{8'h80, 1'b0, 1'b0, RES_NONE},
    '{8'h5a, 1'b0, 1'b0, RES_NONE},
    '{8'ha5, 1'b0, 1'b0, RES_NONE},
    '{8'h3c, 1'b0, 1'b0, RES_NONE},
    '{8'h78, 1'b1, 1'b1, RES_FLAGS},
    '{8'h00, 1'b1, 1'b1, RES_CLEARED},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{8'h01, 1'b0, 1'b0, RES_NONE},
    '{8'h02, 1'b0, 1'b0, RES_NONE},
    '{8'h03, 1'b0, 1'b0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{8'h07, 1'b0, 1'b0, RES_NONE},
    '{8'h00, 1'b0, 1'b0, RES_NONE},
    '{8'h41, 1'b1, 1'b0, RES_NONE}
  };

  int phase_ver  [PHASES] = '{0, 255, 1, 2, 3, 3, -1, 2, 0};
  int phase_src  [4]      = '{0, 48, 0, 35};
  int phase_snk  [4]      = '{0, 0, 48, 35};

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  status_frame_change_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor state
  logic [7:0]            version_q;
  logic [6:0]            pos_q;
  logic [15:0]           chars_q [TEXT_CHARS];
  logic                  spaced_q;
  logic                  text_seen_q;
  logic [15:0]           lead_char_q;
  logic [7:0]            credit_q [CREDIT_N];
  logic [SELECTIONS-1:0] avail_q;
  logic [23:0]           status_q;
  logic [7:0]            prev_imp_q;
  logic [7:0]            flags_q;
  logic [15:0]           beep_q;
  logic [7:0]            lang_q;
  logic [7:0]            imp_q;
  logic [3:0]            diff_q;
  logic [7:0]            lo_byte_q;

  result_t    frame_results_q [$];
  logic [7:0] frame_tpl [FRAME_LEN] = '{default: 8'h00};

  int src_pct     = 0;
  int snk_pct     = 0;
  int hold_req    = 0;
  int err_cnt     = 0;
  int bytes_sent  = 0;
  int frames_sent = 0;
  int results_got = 0;
  int cycle_cnt   = 0;

  task automatic restart_frame();
    pos_q       = '0;
    flags_q     = '0;
    beep_q      = '0;
    lang_q      = '0;
    imp_q       = '0;
    diff_q      = '0;
    lead_char_q = CH_SPACE;
    lo_byte_q   = '0;
  endtask

  task automatic absorb_byte(input int unsigned p, input logic [7:0] b);
    int unsigned off;
    int unsigned idx;
    int unsigned sel;
    int unsigned k;
    logic [15:0] ch;
    if (p >= 3 && p <= 5) begin
      if (status_q[8*(p-3) +: 8] != b) begin
        diff_q[DF_STATE]       = 1'b1;
        status_q[8*(p-3) +: 8] = b;
      end
    end else if (p == POS_FLAGS) begin
      flags_q = b;
    end else if (p >= POS_TEXT && p < POS_AVAIL) begin
      off = p - POS_TEXT;
      idx = (off / 2) % TEXT_CHARS;
      if (off % 2 == 0) begin
        lo_byte_q = b;
      end else begin
        ch = {b, lo_byte_q};
        if (chars_q[idx] != ch) diff_q[DF_TEXT] = 1'b1;
        chars_q[idx] = ch;
        if (idx < TEXT_CHARS / 2 && lead_char_q == CH_SPACE && ch != CH_SPACE) lead_char_q = ch;
      end
    end else if (p >= POS_AVAIL && p < POS_BEEP) begin
      for (k = 0; k < 8; k++) begin
        sel = (p - POS_AVAIL) * 8 + k;
        if (sel < SELECTIONS && avail_q[sel] != !b[k]) begin
          diff_q[DF_AVAIL] = 1'b1;
          avail_q[sel]     = !b[k];
        end
      end
    end
    if (p == POS_BEEP) begin
      beep_q[7:0] = b;
    end else if (p == POS_BEEP_H) begin
      beep_q[15:8] = b;
    end else if (p == POS_LANG) begin
      lang_q = b;
    end else if (p == POS_IMP) begin
      imp_q = b;
    end else if (p >= POS_CREDIT && p <= FRAME_END && version_q >= VER_CREDIT) begin
      idx = (p - POS_CREDIT) % CREDIT_N;
      if (credit_q[idx] != b) begin
        diff_q[DF_CREDIT] = 1'b1;
        credit_q[idx]     = b;
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last,
                              output logic has, output result_t r);
    int unsigned p;
    int unsigned q;
    logic multi;
    logic spaced;
    logic [7:0] imp;
    p   = pos_q;
    r   = '0;
    has = 1'b0;
    absorb_byte(p, b);
    if (!last) begin
      if (pos_q < POS_MAX) pos_q = pos_q + 1'b1;
      return;
    end
    for (q = p + 1; q <= FRAME_END; q++) absorb_byte(q, 8'h00);
    multi  = version_q >= VER_LANG && lang_q == LANG_MULTI;
    imp    = version_q >= VER_CREDIT ? imp_q : IMP_NONE;
    if (avail_q == '0) imp = IMP_NONE;
    spaced = !(multi && lead_char_q == CH_AT);
    r.state_changed  = diff_q[DF_STATE];
    r.machine_state  = status_q[7:0];
    r.error_code     = status_q[15:8];
    r.error_type     = status_q[23:16];
    r.cup_absent     = flags_q[3];
    r.stop_allowed   = flags_q[4];
    r.prep_state     = flags_q[6:5];
    r.beep_ms        = version_q >= VER_BEEP ? 23'(beep_q) * 23'd100 : 23'd0;
    r.credit_changed = diff_q[DF_CREDIT];
    r.avail_changed  = diff_q[DF_AVAIL];
    r.text_changed   = !text_seen_q || spaced != spaced_q || diff_q[DF_TEXT] ||
                       imp != prev_imp_q;
    r.importance     = imp;
    spaced_q    = spaced;
    text_seen_q = 1'b1;
    prev_imp_q  = imp;
    restart_frame();
    has = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [22:0] want, input logic [22:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got = result_t'(m_axis_tdata[62:0]);
    results_got++;
    if (frame_results_q.size() == 0) begin
      $error("result 0x%0h with no frame pending", m_axis_tdata);
      err_cnt++;
    end else begin
      want = frame_results_q.pop_front();
      check_field("state_changed", 23'(want.state_changed), 23'(got.state_changed));
      check_field("machine_state", 23'(want.machine_state), 23'(got.machine_state));
      check_field("error_code", 23'(want.error_code), 23'(got.error_code));
      check_field("error_type", 23'(want.error_type), 23'(got.error_type));
      check_field("cup_absent", 23'(want.cup_absent), 23'(got.cup_absent));
      check_field("stop_allowed", 23'(want.stop_allowed), 23'(got.stop_allowed));
      check_field("prep_state", 23'(want.prep_state), 23'(got.prep_state));
      check_field("beep_ms", want.beep_ms, got.beep_ms);
      check_field("credit_changed", 23'(want.credit_changed), 23'(got.credit_changed));
      check_field("avail_changed", 23'(want.avail_changed), 23'(got.avail_changed));
      check_field("text_changed", 23'(want.text_changed), 23'(got.text_changed));
      check_field("importance", 23'(want.importance), 23'(got.importance));
      check_field("tdata_pad", 23'd0, 23'(m_axis_tdata[63]));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t want);
    logic has;
    result_t pred;
    while ($urandom_range(99) < src_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    predict_byte(b, last, has, pred);
    if (has) frame_results_q.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    version_q    = v;
  endtask

  task automatic run_frame(input int unsigned max_len);
    int unsigned len;
    int unsigned at;
    int unsigned pick;
    int unsigned i;
    logic [15:0] ch;
    pick = $urandom_range(99);
    if (pick < 8) begin
      for (i = 0; i < FRAME_LEN; i++) frame_tpl[i] = 8'($urandom);
    end else begin
      repeat ($urandom_range(0, 3)) frame_tpl[$urandom_range(0, FRAME_END)] = 8'($urandom);
    end
    if ($urandom_range(99) < 20) begin
      at = $urandom_range(0, 20);
      for (i = 0; i < TEXT_CHARS; i++) begin
        if (i < at) ch = CH_SPACE;
        else if (i == at) ch = ($urandom_range(3) == 0) ? {8'($urandom), 8'h40} : CH_AT;
        else ch = {($urandom_range(7) == 0) ? 8'($urandom) : 8'h00, 8'($urandom_range(32, 126))};
        frame_tpl[POS_TEXT + 2 * i]     = ch[7:0];
        frame_tpl[POS_TEXT + 2 * i + 1] = ch[15:8];
      end
    end
    if ($urandom_range(99) < 15) frame_tpl[POS_FLAGS] = 8'($urandom);
    if ($urandom_range(99) < 25)
      frame_tpl[POS_LANG] = ($urandom_range(3) == 0) ? 8'($urandom) : LANG_MULTI;
    if ($urandom_range(99) < 15) frame_tpl[POS_IMP] = 8'($urandom);
    if ($urandom_range(99) < 10) begin
      pick = $urandom_range(2);
      for (i = POS_AVAIL; i < POS_BEEP; i++)
        frame_tpl[i] = (pick == 0) ? 8'hff : (pick == 1) ? 8'h00 : 8'($urandom);
    end
    if ($urandom_range(99) < 15) frame_tpl[POS_CREDIT + $urandom_range(0, 7)] = 8'($urandom);
    if ($urandom_range(99) < 15) frame_tpl[POS_STATE + $urandom_range(0, 2)] = 8'($urandom);
    pick = $urandom_range(99);
    if (max_len != 0) len = $urandom_range(1, max_len);
    else if (pick < 55) len = FRAME_LEN;
    else if (pick < 80) len = $urandom_range(1, FRAME_END);
    else len = $urandom_range(FRAME_LEN + 1, 140);
    for (i = 0; i < len; i++)
      send_byte(i < FRAME_LEN ? frame_tpl[i] : 8'($urandom), i == len - 1, 1'b0, RES_NONE);
    frames_sent++;
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_pct);
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned ph;
    int b0;
    int f0;
    int v;
    version_q   = '0;
    spaced_q    = 1'b0;
    text_seen_q = 1'b0;
    avail_q     = '0;
    status_q    = '0;
    prev_imp_q  = '0;
    for (n = 0; n < TEXT_CHARS; n++) chars_q[n] = '0;
    for (n = 0; n < CREDIT_N; n++) credit_q[n] = '0;
    restart_frame();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DIR_N; n++)
      send_byte(dir_rows[n].data, dir_rows[n].last, dir_rows[n].typed, dir_rows[n].want);
    drain_results();

    for (ph = 0; ph < PHASES; ph++) begin
      v = (phase_ver[ph] < 0) ? int'($urandom_range(0, 255)) : phase_ver[ph];
      write_version(8'(v));
      src_pct = phase_src[ph % 4];
      snk_pct = phase_snk[ph % 4];
      b0 = bytes_sent;
      f0 = frames_sent;
      if (ph == 2) begin
        hold_req = HOLD_CYCLES;
        repeat (12) run_frame(4);
      end
      while (bytes_sent - b0 < PHASE_BYTES || frames_sent - f0 < PHASE_FRMS) begin
        run_frame(0);
        if ($urandom_range(99) < 4) drain_results();
      end
      drain_results();
    end

    $display("Covered %0d frames (%0d bytes, %0d results) over %0d protocol version settings,",
             frames_sent, bytes_sent, results_got, PHASES);
    $display("with short, full and overlong frames and a long output hold-off.");
    if (err_cnt == 0 && frame_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
